// File: src/mvps_pkg.sv
// Shared types and constants for the magnetic vehicle presence scorer.
// Holds the channel payload structs, controller/datapath command types and fixed constants.
// No dependencies.
package mvps_pkg;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
  } sample_t;

  typedef struct packed {
    logic [6:0] magnitude;
    logic [2:0] score;
    logic       fast_recheck;
  } result_t;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_X    = 3'd0;
  localparam logic [2:0] REG_BASE_Y    = 3'd1;
  localparam logic [2:0] REG_BASE_Z    = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_OCCUPIED  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT,
    ST_DONE
  } ctl_state_t;

  // Shared multiplier schedule, one operation per cycle in this order
  typedef enum logic [2:0] {
    MOP_SQ_X,
    MOP_SQ_Y,
    MOP_SQ_Z,
    MOP_PROD_A,
    MOP_PROD_B
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t mul_op;
    logic    root_init;
    logic    root_en;
    logic    finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  // Two square-root digits per cycle, eight digits in total
  localparam int unsigned ROOT_CYCLES = 4;

  // Roots at or above this value give a magnitude above 127
  localparam int unsigned MAG_ROOT_SAT = 160;
  localparam logic [6:0]  MAG_MAX      = 7'd127;
  localparam logic [6:0]  JUMP_LIMIT   = 7'd4;
  localparam logic [14:0] PROD_MAX     = 15'h7FFF;
  localparam logic [14:0] DIFF_MAX     = 15'h7FFF;

  // floor(v/5) = (v * RECIP5) >> RECIP5_SHIFT, exact for v < 2^18
  localparam logic [15:0] RECIP5       = 16'd52429;
  localparam int unsigned RECIP5_SHIFT = 18;

endpackage

// File: src/mvps_ctl.sv
// Sequencer for the presence scorer: accept, multiply schedule, root, result hand-off.
// Depends on mvps_pkg; drives mvps_dp through ctl_cmd_t.
module mvps_ctl
  import mvps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = mul_op_t'(cnt_r);
        if (cnt_r == 3'(MOP_PROD_B)) begin
          // sum of squares is final by now
          cmd.root_init = 1'b1;
          state_nxt     = ST_ROOT;
          cnt_nxt       = '0;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_ROOT: begin
        cmd.root_en = 1'b1;
        if (cnt_r == 3'(ROOT_CYCLES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_load_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_MUL) && (cnt_r == 3'd0))
    else $error("load did not start the multiply schedule");

  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && !$past(state_r == ST_DONE) |-> $past(state_r == ST_ROOT, 1)
      && $past(state_r == ST_ROOT, ROOT_CYCLES))
    else $error("root phase did not last its full cycle count");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == ST_IDLE) && !in_stall)
    else $error("finish did not return to idle");

endmodule

// File: src/mvps_dp.sv
// Datapath for the presence scorer: configuration, shared multiplier, square root,
// scoring and the output register. Depends on mvps_pkg; commanded by mvps_ctl.
module mvps_dp
  import mvps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  sample_t     in_data,
  input  ctl_cmd_t    cmd,
  output dp_status_t  sts,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data
);

  localparam logic [32:0] SQ_SAT = 33'(MAG_ROOT_SAT * MAG_ROOT_SAT);

  typedef struct packed {
    logic [15:0] rad;
    logic [15:0] root;
    logic [15:0] bitv;
  } sqrt_st_t;

  function automatic logic [14:0] abs_sat(input logic [15:0] s, input logic [15:0] b);
    logic [16:0] d;
    logic [16:0] m;
    d = {s[15], s} - {b[15], b};
    m = d[16] ? (17'd0 - d) : d;
    return (m > {2'b00, DIFF_MAX}) ? DIFF_MAX : m[14:0];
  endfunction

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    sqrt_st_t    r;
    logic [15:0] trial;
    r     = s;
    trial = s.root + s.bitv;
    if (s.rad >= trial) begin
      r.rad  = s.rad - trial;
      r.root = (s.root >> 1) + s.bitv;
    end else begin
      r.root = s.root >> 1;
    end
    r.bitv = s.bitv >> 2;
    return r;
  endfunction

  function automatic logic [14:0] prod_term(input logic [14:0] a);
    return (a >= 15'd4) ? (a - 15'd2) : 15'd1;
  endfunction

  // configuration
  logic [15:0] base_x_r, base_y_r, base_z_r;
  logic [14:0] thr_r;
  logic        occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= '0;
      base_y_r <= '0;
      base_z_r <= '0;
      thr_r    <= '0;
      occ_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BASE_X:    base_x_r <= cfg_wdata;
        REG_BASE_Y:    base_y_r <= cfg_wdata;
        REG_BASE_Z:    base_z_r <= cfg_wdata;
        REG_THRESHOLD: thr_r    <= cfg_wdata[14:0];
        REG_OCCUPIED:  occ_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // per-item working registers
  logic [14:0] ax_r, ay_r, az_r, teff_r, prod_r;
  logic [32:0] sq_r;
  sqrt_st_t    sqs_r;
  logic        big_r;

  logic [32:0] tcut_p;
  logic [14:0] mul_a, mul_b;
  logic [29:0] mul_p;
  sqrt_st_t    sqs_adv;

  assign tcut_p = {16'd0, thr_r, 2'b00} * {17'd0, RECIP5};
  assign sqs_adv = sqrt_step(sqrt_step(sqs_r));

  always_comb begin
    mul_a = ax_r;
    mul_b = ax_r;
    case (cmd.mul_op)
      MOP_SQ_X: begin
        mul_a = ax_r;
        mul_b = ax_r;
      end
      MOP_SQ_Y: begin
        mul_a = ay_r;
        mul_b = ay_r;
      end
      MOP_SQ_Z: begin
        mul_a = az_r;
        mul_b = az_r;
      end
      MOP_PROD_A: begin
        mul_a = prod_term(ax_r);
        mul_b = prod_term(ay_r);
      end
      MOP_PROD_B: begin
        mul_a = prod_r;
        mul_b = prod_term(az_r);
      end
      default: ;
    endcase
  end

  assign mul_p = {15'd0, mul_a} * {15'd0, mul_b};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r   <= abs_sat(in_data.sample_x, base_x_r);
      ay_r   <= abs_sat(in_data.sample_y, base_y_r);
      az_r   <= abs_sat(in_data.sample_z, base_z_r);
      teff_r <= occ_r ? tcut_p[RECIP5_SHIFT +: 15] : thr_r;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_op)
        MOP_SQ_X:   sq_r <= {3'd0, mul_p};
        MOP_SQ_Y:   sq_r <= sq_r + {3'd0, mul_p};
        MOP_SQ_Z:   sq_r <= sq_r + {1'b0, mul_p, 2'b00};
        MOP_PROD_A, MOP_PROD_B: begin
          // clamp instead of wrapping
          prod_r <= (mul_p > {15'd0, PROD_MAX}) ? PROD_MAX : mul_p[14:0];
        end
        default: ;
      endcase
    end
    if (cmd.root_init) begin
      big_r       <= (sq_r >= SQ_SAT);
      sqs_r.rad   <= sq_r[15:0];
      sqs_r.root  <= '0;
      sqs_r.bitv  <= 16'h4000;
    end else if (cmd.root_en) begin
      sqs_r <= sqs_adv;
    end
  end

  // result
  logic [25:0] mag_p;
  logic [6:0]  mag;
  logic [6:0]  prev_mag_r;
  logic [6:0]  jump;
  logic [16:0] t3;
  logic [17:0] sum2;
  logic        pass_x, pass_y, pass_z, pass_sum, pass_prod;
  result_t     res;
  result_t     out_data_r;
  logic        out_valid_r;

  assign mag_p = {16'd0, sqs_r.root[7:0], 2'b00} * {10'd0, RECIP5};
  assign mag   = big_r ? MAG_MAX : mag_p[RECIP5_SHIFT +: 7];
  assign jump  = (mag > prev_mag_r) ? (mag - prev_mag_r) : (prev_mag_r - mag);
  assign t3    = {2'b00, teff_r} + {1'b0, teff_r, 1'b0};
  assign sum2  = {2'b00, ax_r, 1'b0} + {2'b00, ay_r, 1'b0} + {2'b00, az_r, 1'b0};

  assign pass_x    = ({3'd0, ax_r} + {1'b0, ax_r, 2'b00}) > {1'b0, t3};
  assign pass_y    = ({3'd0, ay_r} + {1'b0, ay_r, 2'b00}) > {1'b0, t3};
  assign pass_z    = ({3'd0, az_r} + {1'b0, az_r, 2'b00}) > {1'b0, t3};
  assign pass_sum  = sum2 >= {1'b0, t3};
  assign pass_prod = {2'b00, prod_r} >= t3;

  always_comb begin
    res.magnitude    = mag;
    res.score        = {2'b00, pass_x} + {2'b00, pass_y} + {2'b00, pass_z}
                     + {2'b00, pass_sum} + {2'b00, pass_prod};
    res.fast_recheck = occ_r && (jump >= JUMP_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mag_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        prev_mag_r  <= mag;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (sqs_r.bitv == 16'd0))
    else $error("result taken before the square root finished");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r && (prev_mag_r == out_data_r.magnitude))
    else $error("finished result not held in the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

endmodule

// File: src/magnetic_vehicle_presence_scorer.sv
// Magnetic vehicle presence scorer, top level: one result beat per accepted sample.
// An accepted sample runs the multiply schedule and square root, then the result hand-off,
// which waits on out_stall; no sample is accepted before it, given the single shared 15x15
// multiplier and two-digit-per-cycle square root. Reset (rst_n low, synchronous) clears
// the configuration registers, previous magnitude and output valid; no clearing pass.
module magnetic_vehicle_presence_scorer
  import mvps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  sample_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  ctl_cmd_t   cmd;
  dp_status_t sts;

  mvps_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
